/* design/txabs_pkg.sv */
// Shared types and constants for the transmit alternative buffer space model.
`default_nettype none

package txabs_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TB_W = 16;
	localparam int WPB_W = 13;
	localparam int AQ_W = 5;
	localparam int QI_W = 4;
	localparam int BYTES_W = 16;
	localparam int FREE_W = 34;
	localparam int HB_W = 16;
	localparam int PW_W = 12;
	localparam int PROD_W = TB_W + WPB_W;
	localparam int WORDS_W = PROD_W + 1;
	localparam int DIV_BITS = 8;
	localparam int WORD_SHIFT = 5;
	localparam int WORD_BYTES = 32;
	localparam int EARLY_THR = 7;
	localparam int WPB_MIN = 8;

	localparam logic [TB_W-1:0] TB_RESET = 16'd0;
	localparam logic [WPB_W-1:0] WPB_RESET = 13'd64;
	localparam logic [AQ_W-1:0] AQ_RESET = 5'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BUFFERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_BUFFER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_QUEUES = 2'd2;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_SEND = 2'd1,
		CMD_UNSEND = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [HB_W-1:0] quot;
		logic [WPB_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

/* design/tx_alt_buffer_space_model.sv */
// Top level of the transmit alternative queue buffer occupancy model.
//
//  Channel  Handshake              Payload
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//  in       in_valid/in_ready      command, queue_index, packet_bytes
//  out      out_valid/out_ready    accepted, free_bytes
//
// Unsend and reset pass from acceptance through S_HEAD and S_DONE to a loaded result.
// Query and send divide the target head pointer, then walk every active queue through one
// shared divider, dividing each queue's head and then its tail pointer.
// The block takes one transaction at a time; a finished result waits in the output
// register while the next transaction is accepted. Reset sets one queue's tail to its head.
`default_nettype none

module tx_alt_buffer_space_model #(
	parameter int MAX_QUEUES = 16,
	parameter int PTR_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [txabs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [txabs_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input txabs_pkg::cmd_t command,
	input logic [txabs_pkg::QI_W-1:0] queue_index,
	input logic [txabs_pkg::BYTES_W-1:0] packet_bytes,
	output logic out_valid,
	input logic out_ready,
	output logic accepted,
	output logic [txabs_pkg::FREE_W-1:0] free_bytes
);
	import txabs_pkg::*;

	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int QEW = QW + QI_W;
	localparam int CNTW = $clog2(MAX_QUEUES + 1);
	localparam int SUMW = HB_W + 1 + CNTW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAD,
		S_TGT_DIV,
		S_Q_RD,
		S_Q_START,
		S_Q_HWAIT,
		S_Q_TWAIT,
		S_MUL,
		S_FIN,
		S_DONE
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [QW-1:0] q_addr_q;
	logic [PW_W-1:0] pw_q;
	logic [PTR_WIDTH-1:0] tgt_head_q;
	logic [WPB_W-1:0] tgt_ofs_q;
	logic [WPB_W-1:0] ofs_q;
	logic [HB_W-1:0] hb_q;
	logic [PTR_WIDTH-1:0] tail_cur_q;
	logic [CNTW-1:0] i_q;
	logic [SUMW-1:0] sum_q;
	logic [PROD_W-1:0] prod_q;
	logic over_q;
	logic res_acc_q;
	logic [FREE_W-1:0] res_free_q;
	logic out_valid_q;
	logic accepted_q;
	logic [FREE_W-1:0] free_bytes_q;

	logic [TB_W-1:0] total_buffers_q;
	logic [WPB_W-1:0] words_per_buffer_q;
	logic [AQ_W-1:0] active_queues_q;

	logic [WPB_W-1:0] wpb;
	logic [WPB_W-1:0] early_lim;
	logic [CNTW-1:0] nq;
	logic [QEW-1:0] q_ext;
	logic q_valid;
	logic [BYTES_W:0] bytes_rnd;
	logic [PW_W-1:0] pw_in;
	logic [QW-1:0] rd_addr;
	logic [PTR_WIDTH-1:0] head_rd;
	logic [PTR_WIDTH-1:0] tail_rd;
	logic head_we;
	logic [PTR_WIDTH-1:0] head_wdata;
	logic tail_we;
	logic div_start;
	logic [PTR_WIDTH-1:0] div_dividend;
	div_rsp_t div_rsp;
	logic [HB_W:0] q_inuse;
	logic [TB_W-1:0] free_bufs;
	logic [WORDS_W-1:0] words;
	logic [WORDS_W-1:0] words_m1;
	logic fits;
	logic [FREE_W-1:0] free_calc;
	logic in_fire;
	logic res_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_buffers_q <= TB_RESET;
			words_per_buffer_q <= WPB_RESET;
			active_queues_q <= AQ_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TOTAL_BUFFERS: total_buffers_q <= cfg_data[TB_W-1:0];
				CFG_WORDS_PER_BUFFER: words_per_buffer_q <= cfg_data[WPB_W-1:0];
				CFG_ACTIVE_QUEUES: active_queues_q <= cfg_data[AQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign wpb = (words_per_buffer_q < WPB_W'(WPB_MIN)) ? WPB_W'(WPB_MIN) : words_per_buffer_q;
	assign early_lim = wpb - WPB_W'(EARLY_THR);
	assign nq = (8'(active_queues_q) > 8'(MAX_QUEUES)) ? CNTW'(MAX_QUEUES)
		: CNTW'(active_queues_q);

	assign q_ext = QEW'(queue_index);
	assign q_valid = q_ext < QEW'(MAX_QUEUES);
	assign bytes_rnd = {1'b0, packet_bytes} + (BYTES_W + 1)'(WORD_BYTES - 1);
	assign pw_in = PW_W'(bytes_rnd >> WORD_SHIFT) + PW_W'(1);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign rd_addr = (state_q == S_IDLE) ? q_ext[QW-1:0] : i_q[QW-1:0];

	assign head_we = ((state_q == S_HEAD) && (cmd_q == CMD_UNSEND))
		|| ((state_q == S_FIN) && (cmd_q == CMD_SEND) && fits);
	assign head_wdata = (state_q == S_HEAD) ? head_rd - PTR_WIDTH'(pw_q)
		: tgt_head_q + PTR_WIDTH'(pw_q);
	assign tail_we = (state_q == S_HEAD) && (cmd_q == CMD_RESET);

	txabs_ptr_mem #(
		.DEPTH(MAX_QUEUES),
		.W(PTR_WIDTH),
		.AW(QW)
	) u_head_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(rd_addr),
		.rd_data(head_rd),
		.wr_en(head_we),
		.wr_addr(q_addr_q),
		.wr_data(head_wdata)
	);

	txabs_ptr_mem #(
		.DEPTH(MAX_QUEUES),
		.W(PTR_WIDTH),
		.AW(QW)
	) u_tail_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(rd_addr),
		.rd_data(tail_rd),
		.wr_en(tail_we),
		.wr_addr(q_addr_q),
		.wr_data(head_rd)
	);

	assign div_start = ((state_q == S_HEAD) && ((cmd_q == CMD_QUERY) || (cmd_q == CMD_SEND)))
		|| (state_q == S_Q_START)
		|| ((state_q == S_Q_HWAIT) && div_rsp.done);
	assign div_dividend = (state_q == S_Q_HWAIT) ? tail_cur_q : head_rd;

	txabs_div #(
		.W(PTR_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(wpb),
		.rsp(div_rsp)
	);

	// Buffers held by one queue, with the early buffer near the end of the head buffer.
	assign q_inuse = {1'b0, hb_q - div_rsp.quot} + (HB_W + 1)'(1)
		+ (HB_W + 1)'(ofs_q > early_lim);

	assign free_bufs = TB_W'(SUMW'(total_buffers_q) - sum_q);
	assign words = over_q ? '0
		: WORDS_W'(prod_q) + WORDS_W'(wpb) - WORDS_W'(tgt_ofs_q)
		+ ((tgt_ofs_q > early_lim) ? WORDS_W'(wpb) : '0);
	assign words_m1 = words - WORDS_W'(1);
	assign fits = words >= WORDS_W'(pw_q);
	assign free_calc = (words == '0) ? '0 : FREE_W'({words_m1, 5'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_QUERY;
			q_addr_q <= '0;
			pw_q <= '0;
			tgt_head_q <= '0;
			tgt_ofs_q <= '0;
			ofs_q <= '0;
			hb_q <= '0;
			tail_cur_q <= '0;
			i_q <= '0;
			sum_q <= '0;
			prod_q <= '0;
			over_q <= 1'b0;
			res_acc_q <= 1'b0;
			res_free_q <= '0;
			out_valid_q <= 1'b0;
			accepted_q <= 1'b0;
			free_bytes_q <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
				accepted_q <= res_acc_q;
				free_bytes_q <= res_free_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cmd_q <= command;
						q_addr_q <= q_ext[QW-1:0];
						pw_q <= pw_in;
						i_q <= '0;
						sum_q <= '0;
						res_acc_q <= q_valid || (command != CMD_SEND);
						res_free_q <= '0;
						if (q_valid) begin
							state_q <= S_HEAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_HEAD: begin
					tgt_head_q <= head_rd;
					if ((cmd_q == CMD_QUERY) || (cmd_q == CMD_SEND)) begin
						state_q <= S_TGT_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_TGT_DIV: begin
					if (div_rsp.done) begin
						tgt_ofs_q <= div_rsp.rem;
						state_q <= (nq == '0) ? S_MUL : S_Q_START;
					end
				end
				S_Q_RD: begin
					state_q <= S_Q_START;
				end
				S_Q_START: begin
					tail_cur_q <= tail_rd;
					state_q <= S_Q_HWAIT;
				end
				S_Q_HWAIT: begin
					if (div_rsp.done) begin
						hb_q <= div_rsp.quot;
						ofs_q <= div_rsp.rem;
						state_q <= S_Q_TWAIT;
					end
				end
				S_Q_TWAIT: begin
					if (div_rsp.done) begin
						sum_q <= sum_q + SUMW'(q_inuse);
						i_q <= i_q + CNTW'(1);
						state_q <= (i_q + CNTW'(1) == nq) ? S_MUL : S_Q_RD;
					end
				end
				S_MUL: begin
					over_q <= sum_q > SUMW'(total_buffers_q);
					prod_q <= PROD_W'(free_bufs) * PROD_W'(wpb);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd_q == CMD_SEND) begin
						res_acc_q <= fits;
					end else begin
						res_free_q <= free_calc;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = accepted_q;
	assign free_bytes = free_bytes_q;

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(head_we && tail_we))
		else $error("Head and tail stores written in the same cycle.");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_rsp.busy)
		else $error("Divider started while busy.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("Block ready again right after accepting a transaction.");

	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_START) |-> (i_q < nq))
		else $error("Queue walk ran past the active queue count.");

endmodule

`default_nettype wire

/* design/txabs_div.sv */
// Iterative divider of a word pointer by the buffer size, eight quotient bits per cycle.
`default_nettype none

module txabs_div #(
	parameter int W = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] dividend,
	input logic [txabs_pkg::WPB_W-1:0] divisor,
	output txabs_pkg::div_rsp_t rsp
);
	import txabs_pkg::*;

	localparam int STEPS = (W + DIV_BITS - 1) / DIV_BITS;
	localparam int PADW = STEPS * DIV_BITS;
	localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic [PADW-1:0] dvd_q;
	logic [WPB_W-1:0] div_q;
	logic [WPB_W-1:0] rem_q;
	logic [HB_W-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [WPB_W-1:0] rem_nxt;
	logic [DIV_BITS-1:0] qbits;

	always_comb begin
		logic [WPB_W:0] trial;
		rem_nxt = rem_q;
		qbits = '0;
		for (int k = 0; k < DIV_BITS; k++) begin
			trial = {rem_nxt, dvd_q[PADW-1-k]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
				qbits[DIV_BITS-1-k] = 1'b1;
			end
			rem_nxt = trial[WPB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			quot_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q <= PADW'(dividend);
				div_q <= divisor;
				rem_q <= '0;
				quot_q <= '0;
				cnt_q <= CW'(STEPS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= dvd_q << DIV_BITS;
				rem_q <= rem_nxt;
				quot_q <= {quot_q[HB_W-DIV_BITS-1:0], qbits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem = rem_q;

endmodule

`default_nettype wire

/* design/txabs_ptr_mem.sv */
// Word pointer store with one write and one registered read port and per-entry valid bits.
`default_nettype none

module txabs_ptr_mem #(
	parameter int DEPTH = 16,
	parameter int W = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic [AW-1:0] rd_addr,
	output logic [W-1:0] rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [W-1:0] wr_data
);
	logic [W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [W-1:0] rd_data_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// An entry never written since reset reads as zero.
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* dv/tx_alt_buffer_space_model_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the transmit alternative queue buffer space model.
module tx_alt_buffer_space_model_tb;
	import txabs_pkg::*;

	localparam int NUM_Q = 16;
	localparam int PTR_W = 32;
	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int MAX_PRINTS = 30;

	typedef struct packed {
		cmd_t cmd;
		logic [QI_W-1:0] q;
		logic [BYTES_W-1:0] bytes;
	} txn_t;

	typedef struct packed {
		logic acc;
		logic [FREE_W-1:0] free_b;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t command = CMD_QUERY;
	logic [QI_W-1:0] queue_index = '0;
	logic [BYTES_W-1:0] packet_bytes = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic [FREE_W-1:0] free_bytes;

	logic [31:0] hd_word [NUM_Q];
	logic [31:0] tl_word [NUM_Q];
	logic [TB_W-1:0] pool_bufs;
	logic [WPB_W-1:0] buf_words;
	logic [AQ_W-1:0] live_queues;

	txn_t item_backlog [$];
	answer_t pending_answers [$];
	txn_t shown;

	int txns_queued = 0;
	int txns_taken = 0;
	int results_seen = 0;
	int errors = 0;
	int reg_writes = 0;
	int sends_ok = 0;
	int sends_refused = 0;
	int phases_run = 0;
	int send_gap = 0;
	int stall_left = 0;
	int quiet = 0;
	bit idling_on = 1'b1;
	bit long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;

	tx_alt_buffer_space_model #(
		.MAX_QUEUES(NUM_Q),
		.PTR_WIDTH(PTR_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.queue_index(queue_index),
		.packet_bytes(packet_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.free_bytes(free_bytes)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] eff_wpb();
		return (buf_words < WPB_MIN) ? 32'(WPB_MIN) : 32'(buf_words);
	endfunction

	function automatic logic [31:0] bufs_held(int q);
		logic [31:0] wpb, hb, tb, n, ofs;
		wpb = eff_wpb();
		hb = (hd_word[q] / wpb) & 32'hFFFF;
		tb = (tl_word[q] / wpb) & 32'hFFFF;
		n = ((hb - tb) & 32'hFFFF) + 32'd1;
		ofs = (hd_word[q] - hb * wpb) & 32'hFFFF;
		if (ofs > wpb - 32'(EARLY_THR))
			n = n + 32'd1;
		return n;
	endfunction

	function automatic logic [31:0] avail_words(int q);
		longint spare;
		logic [31:0] wpb, words, ofs;
		int nq;
		int i;
		wpb = eff_wpb();
		nq = (live_queues > NUM_Q) ? NUM_Q : int'(live_queues);
		spare = longint'(pool_bufs);
		for (i = 0; i < nq; i++)
			spare = spare - longint'(bufs_held(i));
		if (spare < 0)
			return 32'd0;
		words = 32'(spare) * wpb;
		ofs = hd_word[q] % wpb;
		words = words + (wpb - ofs);
		if (ofs > wpb - 32'(EARLY_THR))
			words = words + wpb;
		return words;
	endfunction

	function automatic answer_t predict_space(txn_t t);
		answer_t a;
		logic [31:0] w, pw;
		a.acc = 1'b1;
		a.free_b = '0;
		pw = (32'(t.bytes) + 32'(WORD_BYTES - 1)) / 32'(WORD_BYTES) + 32'd1;
		case (t.cmd)
			CMD_QUERY: begin
				w = avail_words(t.q);
				if (w > 0)
					w = w - 32'd1;
				a.free_b = FREE_W'(64'(w) * 64'(WORD_BYTES));
			end
			CMD_SEND: begin
				if (avail_words(t.q) < pw)
					a.acc = 1'b0;
				else
					hd_word[t.q] = hd_word[t.q] + pw;
			end
			CMD_UNSEND: begin
				hd_word[t.q] = hd_word[t.q] - pw;
			end
			CMD_RESET: begin
				tl_word[t.q] = hd_word[t.q];
			end
		endcase
		return a;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string what);
		if (errors < MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic add_txn(cmd_t c, int q, int b);
		item_backlog.push_back('{c, QI_W'(q), BYTES_W'(b)});
		txns_queued++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TOTAL_BUFFERS: pool_bufs = data[TB_W-1:0];
			CFG_WORDS_PER_BUFFER: buf_words = data[WPB_W-1:0];
			CFG_ACTIVE_QUEUES: live_queues = data[AQ_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic drain_all();
		do
			@(posedge clk);
		while (txns_taken != txns_queued || pending_answers.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_space(int total, int wpb, int aq);
		drain_all();
		write_reg(CFG_TOTAL_BUFFERS, CFG_DATA_W'(total));
		write_reg(CFG_WORDS_PER_BUFFER, CFG_DATA_W'(wpb));
		write_reg(CFG_ACTIVE_QUEUES, CFG_DATA_W'(aq));
		phases_run++;
	endtask

	task automatic random_phase(int count);
		int nq, k, r, q, b;
		cmd_t c;
		nq = (live_queues > NUM_Q) ? NUM_Q : int'(live_queues);
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85 && nq > 0)
				q = $urandom_range(0, nq - 1);
			else
				q = $urandom_range(0, NUM_Q - 1);
			r = $urandom_range(0, 99);
			if (r < 40)
				c = CMD_SEND;
			else if (r < 70)
				c = CMD_QUERY;
			else if (r < 85)
				c = CMD_RESET;
			else
				c = CMD_UNSEND;
			r = $urandom_range(0, 99);
			if (r < 70)
				b = $urandom_range(0, 2047);
			else if (r < 90)
				b = $urandom_range(0, 65535);
			else
				b = $urandom_range(0, 2047) * WORD_BYTES;
			add_txn(c, q, b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= CMD_QUERY;
			queue_index <= '0;
			packet_bytes <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				answer_t ans;
				ans = predict_space(shown);
				if (shown.cmd == CMD_SEND) begin
					if (ans.acc)
						sends_ok++;
					else
						sends_refused++;
				end
				pending_answers.push_back(ans);
				txns_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					shown = item_backlog.pop_front();
					command <= shown.cmd;
					queue_index <= shown.q;
					packet_bytes <= shown.bytes;
					in_valid <= 1'b1;
					send_gap = idling_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				answer_t want;
				results_seen++;
				if (pending_answers.size() == 0) begin
					report_mismatch("result arrived with no transaction outstanding");
				end else begin
					want = pending_answers.pop_front();
					if (accepted !== want.acc)
						report_mismatch($sformatf("accepted got %0b want %0b",
							accepted, want.acc));
					if (free_bytes !== want.free_b)
						report_mismatch($sformatf("free_bytes got %0d want %0d",
							free_bytes, want.free_b));
				end
			end
			if (long_hold_req && !long_hold_done) begin
				stall_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idling_on && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles", quiet);
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	initial begin
		int p, total, wpb, aq;
		pool_bufs = TB_RESET;
		buf_words = WPB_RESET;
		live_queues = AQ_RESET;
		for (int i = 0; i < NUM_Q; i++) begin
			hd_word[i] = '0;
			tl_word[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		add_txn(CMD_QUERY, 0, 0);
		add_txn(CMD_SEND, 0, 0);

		set_space(65535, 64, 16);
		add_txn(CMD_QUERY, 15, 0);
		add_txn(CMD_SEND, 0, 65535);
		add_txn(CMD_SEND, 0, 0);
		add_txn(CMD_SEND, 1, 32);
		add_txn(CMD_SEND, 1, 33);
		add_txn(CMD_SEND, 3, 1824);
		add_txn(CMD_QUERY, 3, 0);
		add_txn(CMD_UNSEND, 1, 33);
		add_txn(CMD_RESET, 0, 0);
		add_txn(CMD_QUERY, 0, 0);
		add_txn(CMD_UNSEND, 4, 65535);
		add_txn(CMD_QUERY, 4, 0);
		add_txn(CMD_SEND, 4, 100);
		add_txn(CMD_RESET, 4, 0);

		set_space(3, 0, 16'hFFFF);
		add_txn(CMD_QUERY, 0, 0);
		add_txn(CMD_SEND, 0, 0);
		add_txn(CMD_QUERY, 5, 0);

		set_space(3, 7, 0);
		add_txn(CMD_QUERY, 0, 0);
		add_txn(CMD_SEND, 2, 65535);

		for (p = 0; p < 10; p++) begin
			case (p)
				0: begin
					total = 65535;
					wpb = 16'hFFFF;
					aq = 16;
				end
				1: begin
					total = 1;
					wpb = 4096;
					aq = 2;
				end
				2: begin
					total = 0;
					wpb = 8;
					aq = 1;
				end
				default: begin
					case ($urandom_range(0, 5))
						0: total = 0;
						1: total = 65535;
						2: total = 1;
						default: total = $urandom_range(8, 300);
					endcase
					case ($urandom_range(0, 6))
						0: wpb = 0;
						1: wpb = 7;
						2: wpb = 8;
						3: wpb = 16'hFFFF;
						4: wpb = 4096;
						default: wpb = $urandom_range(8, 256);
					endcase
					case ($urandom_range(0, 7))
						0: aq = 0;
						1: aq = 16;
						2: aq = 16'hFFFF;
						3: aq = 17;
						default: aq = $urandom_range(1, 4);
					endcase
				end
			endcase
			set_space(total, wpb, aq);
			idling_on = (p % 4 != 3);
			if (p == 3)
				long_hold_req = 1'b1;
			random_phase(58);
		end

		drain_all();
		repeat (30) @(posedge clk);
		$display("Run covered %0d transactions over %0d register settings (%0d writes).",
			txns_taken, phases_run, reg_writes);
		$display("Checked %0d results; sends admitted %0d, refused %0d; mismatches %0d.",
			results_seen, sends_ok, sends_refused, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
